[sv/stq_pkg.sv]
`default_nettype none
package stq_pkg;

  // Default size of the task table.
  localparam int TASK_COUNT_DEF = 16;

  // Fixed field widths of the channels.
  localparam int MODE_W  = 2;
  localparam int TIME_W  = 32;
  localparam int TID_W   = 4;
  localparam int COUNT_W = 5;

  // Request codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_POLL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DISABLE  = 2'd3;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIND,
    ST_MOVE,
    ST_FIN
  } stq_state_t;

  // Command broadcast from the sequencer to every slot cell.
  typedef struct packed {
    logic shift_in;  // every cell takes its left neighbor, cell 0 takes the new entry
    logic find;      // cell holding the target id raises its marker
    logic set_due;   // the marked cell loads the new due time while finding
    logic go;        // the marker walks one slot to the right
    logic hole;      // marker is a hole (removal) rather than a moving entry
  } cell_cmd_t;

endpackage
`default_nettype wire

[sv/stq_if.sv]
`default_nettype none
interface stq_in_if;
  import stq_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] time_now;
  logic [TIME_W-1:0] handler_delay;
  logic [TID_W-1:0]  task_id;

  modport source (output valid, mode, time_now, handler_delay, task_id, input ready);
  modport sink   (input valid, mode, time_now, handler_delay, task_id, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;

  logic               valid;
  logic               ready;
  logic               due;
  logic [TID_W-1:0]   due_task;
  logic [COUNT_W-1:0] active_count;
  logic               error;

  modport source (output valid, due, due_task, active_count, error, input ready);
  modport sink   (input valid, due, due_task, active_count, error, output ready);
endinterface
`default_nettype wire

[sv/stq_cell.sv]
`default_nettype none
module stq_cell #(
  parameter int ID_W  = 4,
  parameter int LEN_W = 5,
  parameter int INDEX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  stq_pkg::cell_cmd_t             cmd,
  input  wire logic [LEN_W-1:0]          len,
  input  wire logic [ID_W-1:0]           tgt_id,
  input  wire logic [stq_pkg::TIME_W-1:0] new_due,
  input  wire logic [ID_W-1:0]           left_id,
  input  wire logic [stq_pkg::TIME_W-1:0] left_due,
  input  wire logic                      left_adv,
  input  wire logic [ID_W-1:0]           right_id,
  input  wire logic [stq_pkg::TIME_W-1:0] right_due,
  output logic [ID_W-1:0]                slot_id,
  output logic [stq_pkg::TIME_W-1:0]     slot_due,
  output logic                           adv,
  output logic                           done,
  output logic                           match
);
  import stq_pkg::*;

  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TIME_W-1:0] due_r, due_nxt;
  logic              mk_r, mk_nxt;
  logic              occ;
  logic              has_right;

  assign occ       = LEN_W'(INDEX) < len;
  assign has_right = LEN_W'(INDEX + 1) < len;
  assign match     = cmd.find && occ && (id_r == tgt_id);
  // A moving entry passes every right neighbor that is due no later than itself.
  assign adv       = cmd.go && mk_r && has_right && (cmd.hole || (right_due <= due_r));
  assign done      = cmd.go && mk_r && !adv;
  assign slot_id   = id_r;
  assign slot_due  = due_r;

  always_comb begin
    id_nxt  = id_r;
    due_nxt = due_r;
    mk_nxt  = mk_r;
    if (cmd.shift_in) begin
      id_nxt  = left_id;
      due_nxt = left_due;
    end else if (cmd.find) begin
      if (match) begin
        mk_nxt = 1'b1;
        if (cmd.set_due) begin
          due_nxt = new_due;
        end
      end
    end else if (cmd.go) begin
      if (adv) begin
        id_nxt  = right_id;
        due_nxt = right_due;
        mk_nxt  = 1'b0;
      end else if (left_adv) begin
        mk_nxt = 1'b1;
        if (!cmd.hole) begin
          id_nxt  = left_id;
          due_nxt = left_due;
        end
      end
      if (done) begin
        mk_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r  <= ID_W'(INDEX);
      due_r <= '0;
      mk_r  <= 1'b0;
    end else begin
      id_r  <= id_nxt;
      due_r <= due_nxt;
      mk_r  <= mk_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/sorted_timer_task_queue.sv]
// Sorted periodic task queue.
// The input channel carries one request per transfer: a poll with the current
// time, the completion of the running task with the delay it returned, or an
// enable or disable of a task. Each request gives exactly one result transfer
// on the output channel with the due flag, the due task id, the number of
// queued tasks and an error flag.
// The queue lives in a row of slot cells, earliest due task in cell 0. Poll,
// enable and every rejected or deferred request go from the execute state
// straight to the finish state, which loads their result into the output
// register once it is free. Completion and a disable that removes a queued
// task first locate the task in the find state, then walk it through the row
// one slot per cycle in the move state before they reach the finish state.
// A new request is accepted in the cycle after the previous result has been
// loaded into the output register.
// Reset is synchronous: all tasks are enabled and queued in id order, due at
// time zero, and no task is running.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and processed, and its result waits inside the
// block until the output register is free.
`default_nettype none
module sorted_timer_task_queue #(
  parameter int TASK_COUNT = stq_pkg::TASK_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  stq_in_if.sink   in_chan,
  stq_out_if.source out_chan
);
  import stq_pkg::*;

  localparam int ID_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int LEN_W = $clog2(TASK_COUNT + 1);

  // Sequencer and captured request.
  stq_state_t        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] delay_r, delay_nxt;
  logic [TID_W-1:0]  tid_r, tid_nxt;

  // Scheduler state outside the slot row.
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [TIME_W-1:0]     last_time_r, last_time_nxt;
  logic                  run_r, run_nxt;
  logic [ID_W-1:0]       run_id_r, run_id_nxt;
  logic [TASK_COUNT-1:0] en_r, en_nxt;

  // Target of the current queue walk.
  logic [ID_W-1:0]   tgt_r, tgt_nxt;
  logic [TIME_W-1:0] tgt_due_r, tgt_due_nxt;
  logic              hole_r, hole_nxt;

  // Result waiting for the output register.
  logic             res_due_r, res_due_nxt;
  logic [TID_W-1:0] res_task_r, res_task_nxt;
  logic             res_err_r, res_err_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_due_r, out_due_nxt;
  logic [TID_W-1:0]   out_task_r, out_task_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic               out_err_r, out_err_nxt;

  cell_cmd_t cmd;

  logic [ID_W-1:0]   cid   [TASK_COUNT];
  logic [TIME_W-1:0] cdue  [TASK_COUNT];
  logic [TASK_COUNT-1:0] cadv;
  logic [TASK_COUNT-1:0] cdone;
  logic [TASK_COUNT-1:0] cmatch;

  logic            id_ok;
  logic [ID_W-1:0] id_ext;
  logic            any_done;
  logic            found;

  assign id_ok    = 32'(tid_r) < 32'(TASK_COUNT);
  assign id_ext   = ID_W'(tid_r);
  assign any_done = |cdone;
  assign found    = |cmatch;

  // The slot row. Cell 0 takes a newly enabled task from the left, due at the
  // time of the last poll; the last cell has no right neighbor.
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    logic [ID_W-1:0]   l_id;
    logic [TIME_W-1:0] l_due;
    logic              l_adv;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_due;

    if (i == 0) begin : g_first
      assign l_id  = id_ext;
      assign l_due = last_time_r;
      assign l_adv = 1'b0;
    end else begin : g_inner
      assign l_id  = cid[i-1];
      assign l_due = cdue[i-1];
      assign l_adv = cadv[i-1];
    end

    if (i == TASK_COUNT - 1) begin : g_last
      assign r_id  = '0;
      assign r_due = '0;
    end else begin : g_mid
      assign r_id  = cid[i+1];
      assign r_due = cdue[i+1];
    end

    stq_cell #(
      .ID_W  (ID_W),
      .LEN_W (LEN_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .len       (len_r),
      .tgt_id    (tgt_r),
      .new_due   (tgt_due_r),
      .left_id   (l_id),
      .left_due  (l_due),
      .left_adv  (l_adv),
      .right_id  (r_id),
      .right_due (r_due),
      .slot_id   (cid[i]),
      .slot_due  (cdue[i]),
      .adv       (cadv[i]),
      .done      (cdone[i]),
      .match     (cmatch[i])
    );
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.due          = out_due_r;
  assign out_chan.due_task     = out_task_r;
  assign out_chan.active_count = out_cnt_r;
  assign out_chan.error        = out_err_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    time_nxt      = time_r;
    delay_nxt     = delay_r;
    tid_nxt       = tid_r;
    len_nxt       = len_r;
    last_time_nxt = last_time_r;
    run_nxt       = run_r;
    run_id_nxt    = run_id_r;
    en_nxt        = en_r;
    tgt_nxt       = tgt_r;
    tgt_due_nxt   = tgt_due_r;
    hole_nxt      = hole_r;
    res_due_nxt   = res_due_r;
    res_task_nxt  = res_task_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_due_nxt   = out_due_r;
    out_task_nxt  = out_task_r;
    out_cnt_nxt   = out_cnt_r;
    out_err_nxt   = out_err_r;
    cmd           = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          mode_nxt  = in_chan.mode;
          time_nxt  = in_chan.time_now;
          delay_nxt = in_chan.handler_delay;
          tid_nxt   = in_chan.task_id;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_due_nxt  = 1'b0;
        res_task_nxt = '0;
        res_err_nxt  = 1'b0;
        state_nxt    = ST_FIN;
        case (mode_r)
          MODE_POLL: begin
            if (run_r) begin
              res_err_nxt = 1'b1;
            end else if (len_r != '0) begin
              last_time_nxt = time_r;
              if (cdue[0] <= time_r) begin
                run_nxt      = 1'b1;
                run_id_nxt   = cid[0];
                res_due_nxt  = 1'b1;
                res_task_nxt = TID_W'(cid[0]);
              end
            end
          end
          MODE_COMPLETE: begin
            if (!run_r) begin
              res_err_nxt = 1'b1;
            end else begin
              // A task disabled while running leaves the queue; otherwise it
              // moves back to its place for the new due time.
              tgt_nxt     = run_id_r;
              tgt_due_nxt = last_time_r + delay_r;
              hole_nxt    = !en_r[run_id_r];
              run_nxt     = 1'b0;
              state_nxt   = ST_FIND;
            end
          end
          MODE_ENABLE: begin
            if (id_ok) begin
              if (run_r && (run_id_r == id_ext) && !en_r[id_ext]) begin
                en_nxt[id_ext] = 1'b1;
              end else if (!en_r[id_ext] && (len_r < LEN_W'(TASK_COUNT))) begin
                cmd.shift_in   = 1'b1;
                len_nxt        = len_r + LEN_W'(1);
                en_nxt[id_ext] = 1'b1;
              end
            end
          end
          MODE_DISABLE: begin
            if (id_ok) begin
              if (run_r && (run_id_r == id_ext) && en_r[id_ext]) begin
                en_nxt[id_ext] = 1'b0;
              end else if (en_r[id_ext]) begin
                en_nxt[id_ext] = 1'b0;
                tgt_nxt        = id_ext;
                hole_nxt       = 1'b1;
                state_nxt      = ST_FIND;
              end
            end
          end
          default: begin
          end
        endcase
      end

      ST_FIND: begin
        cmd.find    = 1'b1;
        cmd.set_due = !hole_r;
        cmd.hole    = hole_r;
        state_nxt   = found ? ST_MOVE : ST_FIN;
      end

      ST_MOVE: begin
        cmd.go   = 1'b1;
        cmd.hole = hole_r;
        if (any_done) begin
          if (hole_r) begin
            len_nxt = len_r - LEN_W'(1);
          end
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_due_nxt   = res_due_r;
          out_task_nxt  = res_task_r;
          out_cnt_nxt   = COUNT_W'(len_r);
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_W'(TASK_COUNT);
      last_time_r <= '0;
      run_r       <= 1'b0;
      run_id_r    <= '0;
      en_r        <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      last_time_r <= last_time_nxt;
      run_r       <= run_nxt;
      run_id_r    <= run_id_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    time_r     <= time_nxt;
    delay_r    <= delay_nxt;
    tid_r      <= tid_nxt;
    tgt_r      <= tgt_nxt;
    tgt_due_r  <= tgt_due_nxt;
    hole_r     <= hole_nxt;
    res_due_r  <= res_due_nxt;
    res_task_r <= res_task_nxt;
    res_err_r  <= res_err_nxt;
    out_due_r  <= out_due_nxt;
    out_task_r <= out_task_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_err_r  <= out_err_nxt;
  end

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
  import stq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TASKS = TASK_COUNT_DEF;

  // Status of one task in the predicted schedule.
  typedef enum logic [1:0] {
    TS_DISABLED,
    TS_ENABLED,
    TS_RUN_EN,
    TS_RUN_DIS
  } task_state_t;

  // One result transfer as the block should produce it.
  typedef struct packed {
    logic               due;
    logic [TID_W-1:0]   due_task;
    logic [COUNT_W-1:0] active_count;
    logic               error;
  } sched_result_t;

  logic clk;
  logic rst_n;

  stq_in_if  in_bus ();
  stq_out_if out_bus ();

  sorted_timer_task_queue #(
    .TASK_COUNT(TASKS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus.sink),
    .out_chan(out_bus.source)
  );

  // Predicted schedule: slot order, due times, task status and the poll state.
  logic [TID_W-1:0]  slot_id [TASKS];
  logic [TIME_W-1:0] due_at  [TASKS];
  task_state_t       task_st [TASKS];
  int                queued;
  logic [TIME_W-1:0] poll_time;
  logic [TID_W-1:0]  run_id;
  logic              running;

  // Results that the block still owes, oldest first.
  sched_result_t pending_results[$];

  // When calm is set, neither side of the block idles any more.
  bit calm;
  int fail_count;
  int checked_count;
  int sent_count;
  int started_count;
  int rejected_count;
  logic [TIME_W-1:0] wall_ms;

  // The clock runs free for the whole simulation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Position of a task in the predicted queue, or the queue length if absent.
  function automatic int slot_of(logic [TID_W-1:0] id);
    int p;
    p = 0;
    while (p < queued && slot_id[p] != id) p++;
    return p;
  endfunction

  // Closes the gap left by a task taken out of the predicted queue.
  function automatic void drop_slot(int p);
    int i;
    if (p < queued) begin
      for (i = p; i + 1 < queued; i++) slot_id[i] = slot_id[i + 1];
      queued--;
    end
  endfunction

  // Applies one request to the predicted schedule and returns the result
  // that the block has to report for it.
  function automatic sched_result_t step_schedule(logic [MODE_W-1:0] mode,
                                                  logic [TIME_W-1:0] tnow,
                                                  logic [TIME_W-1:0] delay,
                                                  logic [TID_W-1:0]  id);
    sched_result_t     r;
    logic [TID_W-1:0]  h;
    logic [TID_W-1:0]  t;
    logic [TIME_W-1:0] nxt;
    int                p;
    int                w;
    int                i;
    r = '0;
    case (mode)
      MODE_POLL: begin
        if (running) begin
          r.error = 1'b1;
        end else if (queued > 0) begin
          // The poll time is kept even when the head is not yet due.
          h = slot_id[0];
          poll_time = tnow;
          if (due_at[h] <= tnow) begin
            task_st[h] = TS_RUN_EN;
            run_id = h;
            running = 1'b1;
            r.due = 1'b1;
            r.due_task = h;
          end
        end
      end
      MODE_COMPLETE: begin
        if (!running) begin
          r.error = 1'b1;
        end else begin
          t = run_id;
          p = slot_of(t);
          nxt = poll_time + delay;
          due_at[t] = nxt;
          if (task_st[t] == TS_RUN_DIS) begin
            // It was disabled while it ran, so it leaves the queue now.
            drop_slot(p);
            task_st[t] = TS_DISABLED;
          end else begin
            // Walk it back past every entry due no later than its new time.
            if (p < queued) begin
              w = p;
              while (w + 1 < queued && due_at[slot_id[w + 1]] <= nxt) begin
                slot_id[w] = slot_id[w + 1];
                w++;
              end
              slot_id[w] = t;
            end
            task_st[t] = TS_ENABLED;
          end
          running = 1'b0;
        end
      end
      MODE_ENABLE: begin
        if (task_st[id] == TS_RUN_DIS) begin
          task_st[id] = TS_RUN_EN;
        end else if (task_st[id] == TS_DISABLED && queued < TASKS) begin
          for (i = queued; i > 0; i--) slot_id[i] = slot_id[i - 1];
          slot_id[0] = id;
          queued++;
          task_st[id] = TS_ENABLED;
          due_at[id] = poll_time;
        end
      end
      default: begin
        if (task_st[id] == TS_RUN_EN) begin
          task_st[id] = TS_RUN_DIS;
        end else if (task_st[id] == TS_ENABLED) begin
          task_st[id] = TS_DISABLED;
          drop_slot(slot_of(id));
        end
      end
    endcase
    r.active_count = queued[COUNT_W-1:0];
    return r;
  endfunction

  // Sends one request. Inputs change on the falling edge, the handshake is
  // looked at on the rising edge, and the prediction is made at the edge
  // where the transfer happens.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] tnow,
                              logic [TIME_W-1:0] delay, logic [TID_W-1:0] id);
    sched_result_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= mode;
    in_bus.time_now      <= tnow;
    in_bus.handler_delay <= delay;
    in_bus.task_id       <= id;
    do @(posedge clk); while (!in_bus.ready);
    r = step_schedule(mode, tnow, delay, id);
    pending_results.push_back(r);
    sent_count++;
    if (r.due) started_count++;
    if (r.error) rejected_count++;
  endtask

  // Drops valid and holds the sender back until every owed result is in.
  task automatic wait_results_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Walks the corner cases one by one, starting from the reset schedule in
  // which all sixteen tasks are queued in id order and due at time zero.
  task automatic test_directed();
    send_request(MODE_POLL, 32'h0000_0000, 32'h0, 4'd0);     // task 0 is due at once
    send_request(MODE_POLL, 32'h0000_0005, 32'h0, 4'd0);     // poll while it runs
    send_request(MODE_ENABLE, 32'h0, 32'h0, 4'd0);           // already running: ignored
    send_request(MODE_DISABLE, 32'h0, 32'h0, 4'd0);          // deferred disable
    send_request(MODE_ENABLE, 32'h0, 32'h0, 4'd0);           // back to running and enabled
    send_request(MODE_COMPLETE, 32'h0, 32'hFFFF_FFFF, 4'd0); // largest delay, goes last
    send_request(MODE_COMPLETE, 32'h0, 32'h0, 4'd0);         // nothing is running
    send_request(MODE_POLL, 32'hFFFF_FFFF, 32'h0, 4'd15);    // largest time
    send_request(MODE_DISABLE, 32'h0, 32'h0, 4'd1);          // disable while running
    send_request(MODE_COMPLETE, 32'h0, 32'h0000_0003, 4'd1); // removed, due time wraps
    send_request(MODE_DISABLE, 32'h0, 32'h0, 4'd1);          // already disabled
    send_request(MODE_ENABLE, 32'h0, 32'h0, 4'd1);           // front of the queue
    send_request(MODE_POLL, 32'h0000_0064, 32'h0, 4'd0);     // head not yet due
    send_request(MODE_DISABLE, 32'h0, 32'h0, 4'd1);          // remove the queued head
    send_request(MODE_POLL, 32'h0000_0000, 32'h0, 4'd0);
    send_request(MODE_COMPLETE, 32'h0, 32'h0, 4'd0);         // ties with the zero entries
    send_request(MODE_ENABLE, 32'h0, 32'h0, 4'd15);          // queued and enabled: ignored
    send_request(MODE_DISABLE, 32'h0, 32'h0, 4'd15);
    send_request(MODE_ENABLE, 32'h0, 32'h0, 4'd15);
    send_request(MODE_POLL, 32'h8000_0000, 32'h0, 4'd0);
    send_request(MODE_COMPLETE, 32'h0, 32'h7FFF_FFFF, 4'd0); // tie with the latest entry
    send_request(MODE_DISABLE, 32'h0, 32'h0, 4'd0);
  endtask

  // Empties the queue completely, tries a poll and a completion on it, and
  // fills it again in a random order. The sender waits for all results first.
  task automatic test_drain_and_refill();
    int               k;
    int               j;
    logic [TID_W-1:0] ids [TASKS];
    logic [TID_W-1:0] tmp;
    wait_results_drained();
    if (running) send_request(MODE_COMPLETE, $urandom, $urandom_range(0, 50), 4'd0);
    for (k = 0; k < TASKS; k++) send_request(MODE_DISABLE, $urandom, $urandom, k[TID_W-1:0]);
    send_request(MODE_POLL, $urandom, $urandom, TID_W'($urandom));
    send_request(MODE_COMPLETE, $urandom, $urandom, TID_W'($urandom));
    for (k = 0; k < TASKS; k++) ids[k] = k[TID_W-1:0];
    for (k = TASKS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = ids[k];
      ids[k] = ids[j];
      ids[j] = tmp;
    end
    for (k = 0; k < TASKS; k++) send_request(MODE_ENABLE, $urandom, $urandom, ids[k]);
    wait_results_drained();
  endtask

  // Well-formed use of the queue: polls with a clock that mostly moves forward, and
  // a completion after most due reports, mixed with enables, disables and
  // the occasional out-of-turn request. The predicted state steers the mix.
  task automatic run_schedule(int n);
    int                k;
    int                pick;
    int                sel;
    logic [TID_W-1:0]  id;
    logic [TIME_W-1:0] d;
    wall_ms = poll_time;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 9);
      id = (running && sel < 5) ? run_id : TID_W'($urandom);
      if (running) begin
        if (pick < 72) begin
          // Short periods most of the time, now and then a long or wild one.
          if (sel < 6) d = $urandom_range(0, 100);
          else if (sel < 9) d = $urandom_range(0, 5000);
          else d = $urandom;
          send_request(MODE_COMPLETE, $urandom, d, TID_W'($urandom));
        end else if (pick < 80) begin
          send_request(MODE_ENABLE, $urandom, $urandom, id);
        end else if (pick < 92) begin
          send_request(MODE_DISABLE, $urandom, $urandom, id);
        end else begin
          send_request(MODE_POLL, wall_ms, $urandom, id);
        end
      end else begin
        if (pick < 72) begin
          if (sel < 7) wall_ms = wall_ms + $urandom_range(0, 64);
          else if (sel < 9) wall_ms = wall_ms + $urandom_range(0, 2000);
          else wall_ms = $urandom;
          send_request(MODE_POLL, wall_ms, $urandom, id);
        end else if (pick < 86) begin
          send_request(MODE_ENABLE, $urandom, $urandom, id);
        end else if (pick < 96) begin
          send_request(MODE_DISABLE, $urandom, $urandom, id);
        end else begin
          send_request(MODE_COMPLETE, $urandom, $urandom, id);
        end
      end
    end
  endtask

  task automatic test_random_schedule();
    run_schedule(800);
  endtask

  // Requests with every field drawn at random, whatever the schedule holds.
  task automatic test_random_noise();
    int k;
    for (k = 0; k < 150; k++) begin
      send_request(MODE_W'($urandom), $urandom, $urandom, TID_W'($urandom));
    end
  endtask

  // Back-to-back traffic at the end with both sides always ready.
  task automatic test_calm_tail();
    calm = 1'b1;
    run_schedule(120);
  endtask

  // The receiver stalls in random bursts until the calm tail begins.
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
    end
  endfunction

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result transfer with nothing expected, actual due=%0d task=%0d count=%0d error=%0d",
                 $realtime, out_bus.due, out_bus.due_task, out_bus.active_count, out_bus.error);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        check_field("due", 32'(want.due), 32'(out_bus.due));
        check_field("due_task", 32'(want.due_task), 32'(out_bus.due_task));
        check_field("active_count", 32'(want.active_count), 32'(out_bus.active_count));
        check_field("error", 32'(want.error), 32'(out_bus.error));
      end
    end
  end

  // Hard stop in case the block hangs; the normal run is far shorter.
  initial begin
    #5_000_000;
    $display("sorted_timer_task_queue verification failed");
    $finish;
  end

  initial begin
    int k;
    calm = 1'b0;
    fail_count = 0;
    checked_count = 0;
    sent_count = 0;
    started_count = 0;
    rejected_count = 0;
    wall_ms = '0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_POLL;
    in_bus.time_now = '0;
    in_bus.handler_delay = '0;
    in_bus.task_id = '0;
    rst_n = 1'b0;

    // Reset schedule: every task queued in id order, due at zero, none running.
    for (k = 0; k < TASKS; k++) begin
      slot_id[k] = k[TID_W-1:0];
      due_at[k] = '0;
      task_st[k] = TS_ENABLED;
    end
    queued = TASKS;
    poll_time = '0;
    run_id = '0;
    running = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_drain_and_refill();
    test_random_schedule();
    test_random_noise();
    test_calm_tail();

    // Let the last results arrive, then watch a while for stray transfers.
    wait_results_drained();
    repeat (TASKS + 8) @(negedge clk);

    $display("Summary: %0d requests sent, %0d results checked, %0d polls started a task,",
             sent_count, checked_count, started_count);
    $display("  %0d requests rejected; directed corners, drain and refill, random traffic.",
             rejected_count);
    if (fail_count == 0) begin
      $display("sorted_timer_task_queue verification clean");
    end else begin
      $display("sorted_timer_task_queue verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sorted_timer_task_queue.f]
sv/stq_pkg.sv
sv/stq_if.sv
sv/stq_cell.sv
sv/sorted_timer_task_queue.sv
tb/testbench.sv
